### hw/rtl/frls_pkg.sv
// ----------------------------------------------------------------------------
// frls_pkg
// Shared constants and types for the flash record log store.
// ----------------------------------------------------------------------------
package frls_pkg;

  localparam int STORE_BYTES  = 1024;
  localparam int RECORD_BYTES = 2;

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int AW1 = AW + 1;
  localparam int IW  = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_BAD_VALUE = 2'd2;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_CUR_RD,
    S_CUR_WAIT,
    S_CP_RD,
    S_CP_CAP,
    S_ERASE,
    S_PROG,
    S_DONE
  } state_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic [7:0]    wdata;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic [1:0] status;
    logic       record_moved;
    logic       store_erased;
  } result_t;

endpackage

### hw/rtl/frls_mem.sv
// ----------------------------------------------------------------------------
// frls_mem
// Byte-wide store array, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module frls_mem (
  input  logic              clk,
  input  frls_pkg::mem_req_t req,
  output logic [7:0]        rd_data
);
  import frls_pkg::*;

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rd_data_r <= mem[req.addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/frls_ctrl.sv
// ----------------------------------------------------------------------------
// frls_ctrl
// Sequencer: backward scan for the record, byte access, copy, erase sweep.
// ----------------------------------------------------------------------------
module frls_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic [3:0]         in_byte_index,
  input  logic [7:0]         in_new_value,
  output frls_pkg::mem_req_t mem_req,
  input  logic [7:0]         mem_rd_data,
  output logic               res_valid,
  input  logic               res_ready,
  output frls_pkg::result_t  res
);
  import frls_pkg::*;

  state_t        state_r, state_nxt;
  logic          op_r, op_nxt;
  logic [3:0]    idx_r, idx_nxt;
  logic [7:0]    val_r, val_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] paddr_r, paddr_nxt;
  logic          pend_r, pend_nxt;
  logic          issued_r, issued_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    buf_r [RECORD_BYTES];
  logic          buf_we;
  result_t       res_r, res_nxt;

  logic [AW-1:0] last_sel;
  logic [AW-1:0] base_sum;
  logic [AW1-1:0] end_sum;
  logic [7:0]    cur_and;
  logic          cnt_last;

  // address adder for the record byte accesses: current byte, copy and program phases
  always_comb begin
    case (state_r)
      S_CUR_RD, S_CUR_WAIT: base_sum = start_r + AW'(idx_r);
      default:              base_sum = start_r + AW'(cnt_r);
    endcase
  end

  assign end_sum  = AW1'(start_r) + AW1'(2 * RECORD_BYTES);
  assign cur_and  = mem_rd_data & val_r;
  assign cnt_last = (cnt_r == IW'(RECORD_BYTES - 1));
  assign last_sel = (pend_r && mem_rd_data != ERASED_BYTE &&
                     AW1'(paddr_r) > AW1'(RECORD_BYTES - 1))
                    ? paddr_r : AW'(RECORD_BYTES - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r  <= '0;
      pend_r  <= 1'b0;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      addr_r   <= addr_nxt;
      pend_r   <= pend_nxt;
      issued_r <= issued_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    idx_r   <= idx_nxt;
    val_r   <= val_nxt;
    paddr_r <= paddr_nxt;
    start_r <= start_nxt;
    cnt_r   <= cnt_nxt;
    res_r   <= res_nxt;
    if (buf_we) begin
      buf_r[cnt_r] <= mem_rd_data;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    idx_nxt    = idx_r;
    val_nxt    = val_r;
    addr_nxt   = addr_r;
    paddr_nxt  = paddr_r;
    pend_nxt   = pend_r;
    issued_nxt = issued_r;
    start_nxt  = start_r;
    cnt_nxt    = cnt_r;
    res_nxt    = res_r;
    buf_we     = 1'b0;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    mem_req    = '{we: 1'b0, addr: addr_r, wdata: ERASED_BYTE};

    case (state_r)
      S_CLEAR: begin
        mem_req.we = 1'b1;
        if (addr_r == AW'(STORE_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt  = in_opcode;
          idx_nxt = in_byte_index;
          val_nxt = in_new_value;
          res_nxt = '{read_value: 8'd0, status: ST_OK,
                      record_moved: 1'b0, store_erased: 1'b0};
          if ({1'b0, in_byte_index} >= 5'(RECORD_BYTES)) begin
            res_nxt.status = ST_BAD_INDEX;
            state_nxt      = S_DONE;
          end else if (in_opcode == OP_WRITE && in_new_value == ERASED_BYTE) begin
            res_nxt.status = ST_BAD_VALUE;
            state_nxt      = S_DONE;
          end else begin
            addr_nxt   = AW'(STORE_BYTES - 1);
            pend_nxt   = 1'b0;
            issued_nxt = 1'b0;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // one read issued per cycle; data of the previous request checked
        if ((pend_r && mem_rd_data != ERASED_BYTE) || (!pend_r && issued_r)) begin
          start_nxt = last_sel - AW'(RECORD_BYTES - 1);
          pend_nxt  = 1'b0;
          state_nxt = S_CUR_RD;
        end else if (!issued_r) begin
          pend_nxt  = 1'b1;
          paddr_nxt = addr_r;
          if (addr_r == '0) begin
            issued_nxt = 1'b1;
          end else begin
            addr_nxt = addr_r - AW'(1);
          end
        end else begin
          pend_nxt = 1'b0;
        end
      end
      S_CUR_RD: begin
        mem_req.addr = base_sum;
        state_nxt    = S_CUR_WAIT;
      end
      S_CUR_WAIT: begin
        if (op_r == OP_READ) begin
          res_nxt.read_value = mem_rd_data;
          state_nxt          = S_DONE;
        end else if (cur_and == val_r) begin
          // only clears bits: program in place
          mem_req.we         = 1'b1;
          mem_req.addr       = base_sum;
          mem_req.wdata      = cur_and;
          res_nxt.read_value = cur_and;
          state_nxt          = S_DONE;
        end else begin
          res_nxt.record_moved = 1'b1;
          cnt_nxt              = '0;
          state_nxt            = S_CP_RD;
        end
      end
      S_CP_RD: begin
        mem_req.addr = base_sum;
        state_nxt    = S_CP_CAP;
      end
      S_CP_CAP: begin
        buf_we = 1'b1;
        if (cnt_last) begin
          cnt_nxt = '0;
          if (end_sum > AW1'(STORE_BYTES)) begin
            res_nxt.store_erased = 1'b1;
            start_nxt            = '0;
            addr_nxt             = '0;
            state_nxt            = S_ERASE;
          end else begin
            start_nxt = start_r + AW'(RECORD_BYTES);
            state_nxt = S_PROG;
          end
        end else begin
          cnt_nxt   = cnt_r + IW'(1);
          state_nxt = S_CP_RD;
        end
      end
      S_ERASE: begin
        mem_req.we = 1'b1;
        if (addr_r == AW'(STORE_BYTES - 1)) begin
          state_nxt = S_PROG;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      S_PROG: begin
        // target slot is erased, so programming writes the byte as is
        mem_req.we    = 1'b1;
        mem_req.addr  = base_sum;
        mem_req.wdata = (4'(cnt_r) == idx_r) ? val_r : buf_r[cnt_r];
        if (cnt_last) begin
          res_nxt.read_value = val_r;
          state_nxt          = S_DONE;
        end else begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res = res_r;

endmodule

### hw/rtl/flash_record_log_store_unit.sv
// ----------------------------------------------------------------------------
// flash_record_log_store_unit
// Wear-levelled record kept as an append log in an erase-to-0xFF byte store.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in      | request   | in_valid/in_ready, in_opcode, in_byte_index, in_new_value
//  out     | result    | out_valid/out_ready, out_read_value, out_status,
//          |           | out_record_moved, out_store_erased
//
//  After reset a clearing pass writes 0xFF to every byte, in_ready low
//  throughout.
//  A request with a bad index or value goes straight to the result. A read or
//  in-place write first runs the backward scan, which reads one byte per cycle
//  from the top of the store down to the last programmed byte. A moved record
//  adds a copy of the record into a buffer and a program pass into the next
//  slot, and an erase adds a sweep that writes 0xFF to every byte.
//  One request at a time; the result register frees the sequencer as soon
//  as the result is loaded.
// ----------------------------------------------------------------------------
module flash_record_log_store_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_opcode,
  input  logic [3:0] in_byte_index,
  input  logic [7:0] in_new_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_value,
  output logic [1:0] out_status,
  output logic       out_record_moved,
  output logic       out_store_erased
);
  import frls_pkg::*;

  mem_req_t   mem_req;
  logic [7:0] mem_rd_data;
  logic       res_valid;
  logic       res_ready;
  result_t    res;

  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;

  frls_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  frls_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_byte_index (in_byte_index),
    .in_new_value  (in_new_value),
    .mem_req       (mem_req),
    .mem_rd_data   (mem_rd_data),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_value   = out_res_r.read_value;
  assign out_status       = out_res_r.status;
  assign out_record_moved = out_res_r.record_moved;
  assign out_store_erased = out_res_r.store_erased;

  a_erase_implies_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_store_erased |-> out_record_moved)
    else $error("erase reported without a record move");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_read_value == 8'd0 && !out_record_moved && !out_store_erased)
    else $error("rejected request carries data or flags");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_BAD_INDEX ||
                  out_status == ST_BAD_VALUE)
    else $error("undefined status code");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new request taken while one is in progress");

endmodule

### sim/flash_record_log_store_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flash_record_log_store_unit_tb
// Drives read and write requests into the record log store and checks every
// result against a software mirror of the flash array. Covers bad index and
// bad value rejection, in-place programming, record moves, a full-store erase
// and a random mix, with random stalls on both channels.
// ----------------------------------------------------------------------------
module flash_record_log_store_unit_tb;
  import frls_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int TAIL_CYCLES = 2 * STORE_BYTES + 16;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_opcode;
  logic [3:0] in_byte_index;
  logic [7:0] in_new_value;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_read_value;
  logic [1:0] out_status;
  logic       out_record_moved;
  logic       out_store_erased;

  logic [7:0] flash_mirror [STORE_BYTES];
  result_t    expected_results [$];
  result_t    last_prediction;
  result_t    oldest_result;
  bit         gaps_on;
  int         fail_count;
  int         quiet_cycles;

  flash_record_log_store_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_byte_index   (in_byte_index),
    .in_new_value    (in_new_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_record_moved(out_record_moved),
    .out_store_erased(out_store_erased)
  );

  always #10 clk = ~clk;

  // -------------------------------------------------------------------------
  // Flash mirror
  // -------------------------------------------------------------------------
  function automatic logic [7:0] mirror_get(int addr);
    if (addr >= 0 && addr < STORE_BYTES) begin
      return flash_mirror[addr];
    end
    return ERASED_BYTE;
  endfunction

  function automatic void mirror_program(int addr, logic [7:0] v);
    if (addr >= 0 && addr < STORE_BYTES) begin
      flash_mirror[addr] = flash_mirror[addr] & v;
    end
  endfunction

  // base of the live record, found from the last programmed byte
  function automatic int live_record_base();
    int  last;
    int  a;
    bit  found;
    last  = RECORD_BYTES - 1;
    found = 1'b0;
    for (a = STORE_BYTES - 1; a >= 0 && !found; a--) begin
      if (flash_mirror[a] != ERASED_BYTE) begin
        found = 1'b1;
        if (a > last) last = a;
      end
    end
    return last + 1 - RECORD_BYTES;
  endfunction

  function automatic result_t apply_request(logic op, logic [3:0] idx, logic [7:0] val);
    result_t    r;
    int         base;
    int         i;
    logic [7:0] cur;
    logic [7:0] snapshot [RECORD_BYTES];
    r = '0;
    if (idx >= RECORD_BYTES) begin
      r.status = ST_BAD_INDEX;
    end else if (op == OP_READ) begin
      r.read_value = mirror_get(live_record_base() + idx);
    end else if (val == ERASED_BYTE) begin
      r.status = ST_BAD_VALUE;
    end else begin
      base = live_record_base();
      cur  = mirror_get(base + idx);
      if ((cur & val) != val) begin
        // new value sets a cleared bit: copy the record to the next slot
        for (i = 0; i < RECORD_BYTES; i++) snapshot[i] = mirror_get(base + i);
        base += RECORD_BYTES;
        if (base + RECORD_BYTES > STORE_BYTES) begin
          foreach (flash_mirror[a]) flash_mirror[a] = ERASED_BYTE;
          base           = 0;
          r.store_erased = 1'b1;
        end
        for (i = 0; i < RECORD_BYTES; i++) begin
          if (i != idx) mirror_program(base + i, snapshot[i]);
        end
        r.record_moved = 1'b1;
      end
      mirror_program(base + idx, val);
      r.read_value = mirror_get(base + idx);
    end
    return r;
  endfunction

  // a legal value that cannot be programmed in place over cur, unless cur is erased
  function automatic logic [7:0] value_forcing_move(logic [7:0] cur);
    logic [7:0] v;
    if (cur == ERASED_BYTE) begin
      return 8'($urandom_range(0, 254));
    end
    v = cur;
    while ((cur & v) == v) v = 8'($urandom_range(0, 254));
    return v;
  endfunction

  // -------------------------------------------------------------------------
  // Request driver
  // -------------------------------------------------------------------------
  task automatic send_request(logic op, logic [3:0] idx, logic [7:0] val);
    while (gaps_on && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_byte_index <= idx;
    in_new_value  <= val;
    do @(posedge clk); while (!in_ready);
    last_prediction = apply_request(op, idx, val);
    expected_results.push_back(last_prediction);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= !gaps_on || ($urandom_range(0, 99) >= 19);
  end

  // -------------------------------------------------------------------------
  // Result checker
  // -------------------------------------------------------------------------
  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none, got %0d/%0d/%0d/%0d",
                 $time, out_read_value, out_status, out_record_moved, out_store_erased);
        fail_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("read_value", oldest_result.read_value, out_read_value);
        check_field("status", oldest_result.status, out_status);
        check_field("record_moved", oldest_result.record_moved, out_record_moved);
        check_field("store_erased", oldest_result.store_erased, out_store_erased);
      end
    end
  end

  // any handshake counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[flash_record_log_store_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  task automatic test_directed();
    send_request(OP_READ,  4'd0,  8'h00);   // fresh store reads erased
    send_request(OP_READ,  4'd1,  8'hFF);
    send_request(OP_READ,  4'd15, 8'h12);
    send_request(OP_WRITE, 4'd15, 8'hFF);   // index beats value check
    send_request(OP_WRITE, 4'd0,  8'hFF);
    send_request(OP_READ,  4'd2,  8'hFF);
    send_request(OP_WRITE, 4'd8,  8'h00);
    send_request(OP_WRITE, 4'd0,  8'hA5);   // programs over erased bytes
    send_request(OP_WRITE, 4'd1,  8'h5A);
    send_request(OP_READ,  4'd0,  8'h00);
    send_request(OP_READ,  4'd1,  8'hFF);
    send_request(OP_WRITE, 4'd0,  8'h01);   // clears bits only
    send_request(OP_WRITE, 4'd0,  8'h00);
    send_request(OP_WRITE, 4'd0,  8'hFE);   // needs a move
    send_request(OP_WRITE, 4'd1,  8'hFF);
    send_request(OP_READ,  4'd0,  8'h7F);
    send_request(OP_READ,  4'd1,  8'h80);
    send_request(OP_WRITE, 4'd1,  8'h80);
    send_request(OP_WRITE, 4'd1,  8'h7F);
    send_request(OP_WRITE, 4'd1,  8'h7F);   // same value again, in place
    send_request(OP_READ,  4'd0,  8'h55);
    send_request(OP_READ,  4'd1,  8'hAA);
  endtask

  // keep moving the record until it wraps through an erase, then a few more
  task automatic test_fill_to_erase();
    int         n;
    int         after_erase;
    bit         erase_seen;
    logic [3:0] idx;
    logic [7:0] cur;
    n           = 0;
    after_erase = 0;
    erase_seen  = 1'b0;
    while (after_erase < 8 && n < 1200) begin
      gaps_on = !(n >= 150 && n < 300);
      idx     = 4'($urandom_range(0, RECORD_BYTES - 1));
      if ($urandom_range(0, 99) < 10) begin
        send_request(OP_READ, idx, 8'($urandom_range(0, 255)));
      end else begin
        cur = mirror_get(live_record_base() + idx);
        send_request(OP_WRITE, idx, value_forcing_move(cur));
        if (last_prediction.store_erased) erase_seen = 1'b1;
      end
      if (erase_seen) after_erase++;
      n++;
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_mix();
    int         n;
    int         pick;
    logic [3:0] idx;
    logic [7:0] cur;
    logic [7:0] v;
    for (n = 0; n < 70; n++) begin
      pick = $urandom_range(0, 99);
      idx  = 4'($urandom_range(0, RECORD_BYTES - 1));
      cur  = mirror_get(live_record_base() + idx);
      if (pick < 25) begin
        send_request(OP_READ, idx, 8'($urandom_range(0, 255)));
      end else if (pick < 45) begin
        v = cur & 8'($urandom_range(0, 255));
        if (v == ERASED_BYTE) v = 8'hFE;
        send_request(OP_WRITE, idx, v);
      end else if (pick < 75) begin
        send_request(OP_WRITE, idx, value_forcing_move(cur));
      end else if (pick < 90) begin
        send_request(1'($urandom_range(0, 1)), 4'($urandom_range(RECORD_BYTES, 15)),
                     8'($urandom_range(0, 255)));
      end else begin
        send_request(OP_WRITE, idx, ERASED_BYTE);
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_READ;
    in_byte_index = 4'd0;
    in_new_value  = 8'd0;
    out_ready     = 1'b0;
    gaps_on       = 1'b1;
    fail_count    = 0;
    quiet_cycles  = 0;
    foreach (flash_mirror[a]) flash_mirror[a] = ERASED_BYTE;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_to_erase();
    test_random_mix();
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[flash_record_log_store_unit] OK");
    end else begin
      $display("[flash_record_log_store_unit] ERROR");
    end
    $finish;
  end

endmodule

### flash_record_log_store_unit.f
hw/rtl/frls_pkg.sv
hw/rtl/frls_mem.sv
hw/rtl/frls_ctrl.sv
hw/rtl/flash_record_log_store_unit.sv
sim/flash_record_log_store_unit_tb.sv
